// ----- src/linear_memory_access_unit_defines.svh -----
// Assertion macros used by the checker of the linear memory access unit.
`ifndef LINEAR_MEMORY_ACCESS_UNIT_DEFINES_SVH
`define LINEAR_MEMORY_ACCESS_UNIT_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define LMAU_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("linear memory access unit check failed");

// The consequent holds in the cycle after the antecedent.
`define LMAU_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("linear memory access unit check failed");

`endif

// ----- src/lmau_pkg.sv -----
package lmau_pkg;

   // Default size of the physical byte store.
   localparam int LMAU_MEM_BYTES = 65536;

   // Width of the configuration register index.
   localparam int LMAU_CSR_IDX_W = 3;
   localparam int LMAU_CSR_DATA_W = 32;

   // Request operations.
   localparam logic [1:0] FN_LOAD = 2'd0;
   localparam logic [1:0] FN_STORE = 2'd1;
   localparam logic [1:0] FN_GROW = 2'd2;
   localparam logic [1:0] FN_SIZE = 2'd3;

   // Access widths.
   localparam logic [1:0] SC_1 = 2'd0;
   localparam logic [1:0] SC_2 = 2'd1;
   localparam logic [1:0] SC_4 = 2'd2;
   localparam logic [1:0] SC_8 = 2'd3;

   // Value types.
   localparam logic [1:0] VT_I32 = 2'd0;
   localparam logic [1:0] VT_I64 = 2'd1;
   localparam logic [1:0] VT_F32 = 2'd2;
   localparam logic [1:0] VT_F64 = 2'd3;

   // Result status codes.
   localparam logic [2:0] STS_OK = 3'd0;
   localparam logic [2:0] STS_OOB = 3'd1;
   localparam logic [2:0] STS_UNALIGNED = 3'd2;
   localparam logic [2:0] STS_REFUSED = 3'd3;
   localparam logic [2:0] STS_BADTYPE = 3'd4;

   // Configuration register indexes.
   localparam logic [LMAU_CSR_IDX_W-1:0] CSR_PAGE_LOG2 = 3'd0;
   localparam logic [LMAU_CSR_IDX_W-1:0] CSR_MAX_PAGES = 3'd1;
   localparam logic [LMAU_CSR_IDX_W-1:0] CSR_HAS_MAX = 3'd2;
   localparam logic [LMAU_CSR_IDX_W-1:0] CSR_INIT_PAGES = 3'd3;

   // Sequencer states.
   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_EXEC  = 9'b000000100,
      S_RD1   = 9'b000001000,
      S_RD2   = 9'b000010000,
      S_CVT   = 9'b000100000,
      S_WR0   = 9'b001000000,
      S_WR1   = 9'b010000000,
      S_PUSH  = 9'b100000000
   } lmau_state_type;

   // Half to single precision; NaNs come out quiet with the payload kept.
   function automatic logic [31:0] lmau_half_to_single(input logic [15:0] h);
      logic       s;
      logic [4:0] e;
      logic [9:0] m;
      logic [3:0] k;
      logic [9:0] mn;
      logic [7:0] es;
      logic [31:0] r;
      s = h[15];
      e = h[14:10];
      m = h[9:0];
      k = 4'd0;
      // Shift that brings the leading one of a subnormal to the hidden bit.
      for (int i = 0; i < 10; i++) begin
         if (m[i]) begin
            k = 4'(10 - i);
         end
      end
      mn = 10'(m << k);
      es = 8'd113 - 8'(k);
      if (e == 5'h1F) begin
         if (m == 10'd0) begin
            r = {s, 8'hFF, 23'd0};
         end else begin
            r = {s, 8'hFF, 23'h400000 | {m, 13'd0}};
         end
      end else if (e == 5'd0) begin
         if (m == 10'd0) begin
            r = {s, 31'd0};
         end else begin
            r = {s, es, mn, 13'd0};
         end
      end else begin
         r = {s, 8'(e) + 8'd112, m, 13'd0};
      end
      return r;
   endfunction

   // Single to half precision with round to nearest even.
   function automatic logic [15:0] lmau_single_to_half(input logic [31:0] f);
      logic        s;
      logic [7:0]  e;
      logic [22:0] m;
      logic [14:0] v;
      logic [12:0] rr;
      logic [31:0] full;
      logic [7:0]  sh;
      logic [31:0] q;
      logic [31:0] rem;
      logic [31:0] hf;
      logic [15:0] r;
      s = f[31];
      e = f[30:23];
      m = f[22:0];
      full = {8'd0, 1'b1, m};
      sh = 8'd126 - e;
      v = '0;
      rr = '0;
      q = '0;
      rem = '0;
      hf = '0;
      if (e == 8'hFF) begin
         r = {s, (m != 23'd0) ? 15'h7E00 : 15'h7C00};
      end else if (e >= 8'd143) begin
         r = {s, 15'h7C00};
      end else if (e >= 8'd113) begin
         v = {5'(e - 8'd112), m[22:13]};
         rr = m[12:0];
         if (rr > 13'h1000 || (rr == 13'h1000 && v[0])) begin
            v = v + 15'd1;
         end
         r = {s, v};
      end else if (e == 8'd0 || sh > 8'd24) begin
         r = {s, 15'd0};
      end else begin
         q = full >> sh[4:0];
         rem = full & ((32'd1 << sh[4:0]) - 32'd1);
         hf = 32'd1 << (sh[4:0] - 5'd1);
         if (rem > hf || (rem == hf && q[0])) begin
            q = q + 32'd1;
         end
         r = {s, q[14:0]};
      end
      return r;
   endfunction

endpackage

// ----- src/lmau_if.sv -----
// Request channel.
interface lmau_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] address;
   logic [31:0] offset;
   logic [1:0]  size_code;
   logic        atomic;
   logic [1:0]  value_type;
   logic        sign_extend;
   logic [63:0] store_data;
   logic [16:0] grow_pages;

   modport source (output valid, func, address, offset, size_code, atomic, value_type,
                   sign_extend, store_data, grow_pages, input ready);
   modport sink (input valid, func, address, offset, size_code, atomic, value_type,
                 sign_extend, store_data, grow_pages, output ready);
endinterface

// Response channel.
interface lmau_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] load_data;
   logic [2:0]  status;
   logic [16:0] size_bytes;

   modport source (output valid, load_data, status, size_bytes, input ready);
   modport sink (input valid, load_data, status, size_bytes, output ready);
endinterface

// Configuration write channel.
interface lmau_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- src/lmau_ram.sv -----
module lmau_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [WIDTH/8-1:0]       wbe,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Byte-enabled write, registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         for (int i = 0; i < WIDTH / 8; i++) begin
            if (wbe[i]) begin
               mem[waddr][8*i +: 8] <= wdata[8*i +: 8];
            end
         end
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- src/linear_memory_access_unit.sv -----
// Byte-addressed linear memory with load, store, grow and size requests. The byte
// store is one RAM of 8-byte words with a single write and a single read port, and a
// small sequencer drives every request. A load makes two word reads and then extends
// or converts; a store makes two byte-enabled word writes; size and grow go straight
// to the response, but a grow that exposes new bytes first zeroes them word by word.
// Writing initial_pages to a larger size likewise zeroes the new words before the
// next request is taken. After reset the whole store is cleared, while configuration
// writes are still taken. A new request may be taken while the previous result
// waits.
module linear_memory_access_unit
   import lmau_pkg::*;
#(
   parameter int MEM_BYTES = LMAU_MEM_BYTES
) (
   input logic        clock,
   input logic        reset,
   lmau_req_if.sink   req_ch,
   lmau_rsp_if.source rsp_ch,
   lmau_csr_if.sink   csr_ch
);

   localparam int DEPTH = (MEM_BYTES + 7) / 8;
   localparam int DW = $clog2(DEPTH);
   localparam int SW = $clog2(MEM_BYTES) + 1;
   localparam logic [SW-1:0] MEM_SZ = SW'(MEM_BYTES);
   localparam logic [SW-1:0] SIZE_RST = SW'((MEM_BYTES < 65536) ? MEM_BYTES : 65536);

   // Control and configuration registers.
   lmau_state_type state_ff, state_in;
   logic           boot_ff, boot_in;
   logic           clr_push_ff, clr_push_in;
   logic [DW-1:0]  clr_ff, clr_in;
   logic [DW-1:0]  clr_end_ff, clr_end_in;
   logic [SW-1:0]  lo_ff, lo_in;
   logic [SW-1:0]  hi_ff, hi_in;
   logic [SW-1:0]  size_ff, size_in;
   logic [4:0]     psl_ff, psl_in;
   logic [16:0]    maxp_ff, maxp_in;
   logic           hasmax_ff, hasmax_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Request and result payload registers.
   logic [1:0]  func_ff, func_in;
   logic [32:0] ea_ff, ea_in;
   logic [1:0]  sc_ff, sc_in;
   logic        atom_ff, atom_in;
   logic [1:0]  vt_ff, vt_in;
   logic        sx_ff, sx_in;
   logic [63:0] sd_ff, sd_in;
   logic [16:0] gp_ff, gp_in;
   logic [63:0] word0_ff, word0_in;
   logic [63:0] raw_ff, raw_in;
   logic [2:0]  res_status_ff, res_status_in;
   logic [63:0] res_data_ff, res_data_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [16:0] rsp_size_ff, rsp_size_in;

   // RAM port.
   logic          ram_we;
   logic [DW-1:0] ram_waddr;
   logic [63:0]   ram_wdata;
   logic [7:0]    ram_wbe;
   logic [DW-1:0] ram_raddr;
   logic [63:0]   ram_rdata;

   // Shared helpers.
   logic          req_fire;
   logic          csr_fire;
   logic [DW-1:0] w0;
   logic [DW-1:0] w1;
   logic [2:0]    bsh;
   logic [3:0]    nbytes;
   logic [63:0]   nmask;
   logic          ok_type;
   logic          oob;
   logic          unal;
   logic [31:0]   memp;
   logic [31:0]   newp;
   logic [31:0]   newb32;
   logic          refuse;
   logic [31:0]   ip32;
   logic [31:0]   ipb32;
   logic [SW-1:0] init_sz;
   logic [7:0]    clr_be;
   logic [127:0]  wr_wide;
   logic [15:0]   wr_be;
   logic [127:0]  rd_pair;
   logic [63:0]   ext;
   logic          sign_bit;
   logic [SW+2:0] lo_x;
   logic [SW+2:0] hi_x;
   logic [SW+16:0] size_wide;

   lmau_ram #(
      .WIDTH(64),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .wbe  (ram_wbe),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // Handshakes.
   assign req_fire = req_ch.valid && req_ch.ready;
   assign csr_fire = csr_ch.valid && csr_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && !csr_ch.valid;
   assign csr_ch.ready = (state_ff == S_IDLE) || ((state_ff == S_CLEAR) && boot_ff);

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.load_data = rsp_data_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.size_bytes = rsp_size_ff;

   // Word addresses and access width of the latched request.
   assign w0 = ea_ff[DW+2:3];
   assign w1 = w0 + DW'(1);
   assign bsh = ea_ff[2:0];
   assign nbytes = 4'(4'd1 << sc_ff);

   always_comb begin
      case (sc_ff)
         SC_1: nmask = 64'h0000_0000_0000_00FF;
         SC_2: nmask = 64'h0000_0000_0000_FFFF;
         SC_4: nmask = 64'h0000_0000_FFFF_FFFF;
         default: nmask = '1;
      endcase
   end

   // Type, bounds and alignment checks.
   assign ok_type = (vt_ff == VT_I32 && sc_ff != SC_8) || (vt_ff == VT_I64) ||
                    (vt_ff == VT_F32 && (sc_ff == SC_2 || sc_ff == SC_4)) ||
                    (vt_ff == VT_F64 && sc_ff == SC_8);
   assign oob = ({1'b0, ea_ff} + 34'(nbytes)) > 34'(size_ff);
   assign unal = atom_ff && (sc_ff != SC_1) && ((ea_ff[2:0] & 3'(nbytes - 4'd1)) != 3'd0);

   // Grow arithmetic in pages; byte size is only used when it fits.
   assign memp = 32'(MEM_SZ >> psl_ff);
   assign newp = 32'(size_ff >> psl_ff) + 32'(gp_ff);
   assign newb32 = newp << psl_ff;
   assign refuse = (hasmax_ff && newp > 32'(maxp_ff)) || (newp > memp);

   // Size loaded from a newly written initial_pages, saturated.
   assign ip32 = 32'(csr_ch.data[16:0]);
   assign ipb32 = ip32 << psl_ff;
   assign init_sz = (ip32 > memp) ? MEM_SZ : ipb32[SW-1:0];

   // Byte enables of the clearing pass for the current word.
   assign lo_x = (SW+3)'(lo_ff);
   assign hi_x = (SW+3)'(hi_ff);
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         clr_be[i] = ((SW+3)'({clr_ff, 3'(i)}) >= lo_x) &&
                     ((SW+3)'({clr_ff, 3'(i)}) < hi_x);
      end
   end

   // Store data and load data aligned to the word pair.
   assign wr_wide = {64'd0, sd_ff} << {bsh, 3'd0};
   assign wr_be = {8'd0, nmask[7:0] & 8'((16'd1 << nbytes) - 16'd1)} << bsh;
   assign rd_pair = {ram_rdata, word0_ff} >> {bsh, 3'd0};

   // Sign of a narrow integer load.
   always_comb begin
      case (sc_ff)
         SC_1: sign_bit = raw_ff[7];
         SC_2: sign_bit = raw_ff[15];
         SC_4: sign_bit = raw_ff[31];
         default: sign_bit = raw_ff[63];
      endcase
      ext = (sx_ff && sign_bit) ? (raw_ff | ~nmask) : raw_ff;
   end

   assign size_wide = {17'd0, size_ff};

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      boot_in = boot_ff;
      clr_push_in = clr_push_ff;
      clr_in = clr_ff;
      clr_end_in = clr_end_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      size_in = size_ff;
      psl_in = psl_ff;
      maxp_in = maxp_ff;
      hasmax_in = hasmax_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      func_in = func_ff;
      ea_in = ea_ff;
      sc_in = sc_ff;
      atom_in = atom_ff;
      vt_in = vt_ff;
      sx_in = sx_ff;
      sd_in = sd_ff;
      gp_in = gp_ff;
      word0_in = word0_ff;
      raw_in = raw_ff;
      res_status_in = res_status_ff;
      res_data_in = res_data_ff;
      rsp_data_in = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_size_in = rsp_size_ff;
      ram_we = 1'b0;
      ram_waddr = w0;
      ram_wdata = '0;
      ram_wbe = '0;
      ram_raddr = w0;

      case (state_ff)
         S_CLEAR: begin
            // Zero one word of the range per cycle.
            ram_we = 1'b1;
            ram_waddr = clr_ff;
            ram_wbe = clr_be;
            if (clr_ff == clr_end_ff) begin
               boot_in = 1'b0;
               state_in = clr_push_ff ? S_PUSH : S_IDLE;
            end else begin
               clr_in = clr_ff + DW'(1);
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               func_in = req_ch.func;
               ea_in = {1'b0, req_ch.address} + {1'b0, req_ch.offset};
               sc_in = req_ch.size_code;
               atom_in = req_ch.atomic;
               vt_in = req_ch.value_type;
               sx_in = req_ch.sign_extend;
               sd_in = req_ch.store_data;
               gp_in = req_ch.grow_pages;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_data_in = '0;
            res_status_in = STS_OK;
            state_in = S_PUSH;
            if (func_ff == FN_GROW) begin
               if (refuse) begin
                  res_status_in = STS_REFUSED;
               end else begin
                  size_in = newb32[SW-1:0];
                  if (newb32[SW-1:0] > size_ff) begin
                     lo_in = size_ff;
                     hi_in = newb32[SW-1:0];
                     clr_in = size_ff[DW+2:3];
                     clr_end_in = DW'(((SW+3)'(newb32[SW-1:0]) - (SW+3)'(1)) >> 3);
                     clr_push_in = 1'b1;
                     state_in = S_CLEAR;
                  end
               end
            end else if (func_ff == FN_LOAD || func_ff == FN_STORE) begin
               if (!ok_type) begin
                  res_status_in = STS_BADTYPE;
               end else if (oob) begin
                  res_status_in = STS_OOB;
               end else if (unal) begin
                  res_status_in = STS_UNALIGNED;
               end else if (func_ff == FN_LOAD) begin
                  ram_raddr = w0;
                  state_in = S_RD1;
               end else begin
                  if (vt_ff == VT_F32 && sc_ff == SC_2) begin
                     sd_in = {48'd0, lmau_single_to_half(sd_ff[31:0])};
                  end
                  state_in = S_WR0;
               end
            end
         end
         S_RD1: begin
            word0_in = ram_rdata;
            ram_raddr = w1;
            state_in = S_RD2;
         end
         S_RD2: begin
            raw_in = rd_pair[63:0] & nmask;
            state_in = S_CVT;
         end
         S_CVT: begin
            // Extend narrow integers, widen halves, pass the rest.
            if (vt_ff == VT_F32 && sc_ff == SC_2) begin
               res_data_in = {32'd0, lmau_half_to_single(raw_ff[15:0])};
            end else if ((vt_ff == VT_I32 || vt_ff == VT_I64) && sc_ff != SC_8) begin
               res_data_in = (vt_ff == VT_I32) ? {32'd0, ext[31:0]} : ext;
            end else begin
               res_data_in = raw_ff;
            end
            state_in = S_PUSH;
         end
         S_WR0: begin
            ram_we = 1'b1;
            ram_waddr = w0;
            ram_wdata = wr_wide[63:0];
            ram_wbe = wr_be[7:0];
            state_in = S_WR1;
         end
         S_WR1: begin
            ram_we = 1'b1;
            ram_waddr = w1;
            ram_wdata = wr_wide[127:64];
            ram_wbe = wr_be[15:8];
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_data_ff;
               rsp_status_in = res_status_ff;
               rsp_size_in = size_wide[16:0];
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Configuration writes.
      if (csr_fire) begin
         case (csr_ch.index)
            CSR_PAGE_LOG2: psl_in = csr_ch.data[4:0];
            CSR_MAX_PAGES: maxp_in = csr_ch.data[16:0];
            CSR_HAS_MAX: hasmax_in = csr_ch.data[0];
            CSR_INIT_PAGES: begin
               size_in = init_sz;
               // Zero the newly exposed bytes unless the reset pass still runs.
               if (!boot_ff && init_sz > size_ff) begin
                  lo_in = size_ff;
                  hi_in = init_sz;
                  clr_in = size_ff[DW+2:3];
                  clr_end_in = DW'(((SW+3)'(init_sz) - (SW+3)'(1)) >> 3);
                  clr_push_in = 1'b0;
                  state_in = S_CLEAR;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         boot_ff <= 1'b1;
         clr_push_ff <= 1'b0;
         clr_ff <= '0;
         clr_end_ff <= DW'(DEPTH - 1);
         lo_ff <= '0;
         hi_ff <= MEM_SZ;
         size_ff <= SIZE_RST;
         psl_ff <= 5'd16;
         maxp_ff <= 17'd65536;
         hasmax_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         boot_ff <= boot_in;
         clr_push_ff <= clr_push_in;
         clr_ff <= clr_in;
         clr_end_ff <= clr_end_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         size_ff <= size_in;
         psl_ff <= psl_in;
         maxp_ff <= maxp_in;
         hasmax_ff <= hasmax_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff <= func_in;
      ea_ff <= ea_in;
      sc_ff <= sc_in;
      atom_ff <= atom_in;
      vt_ff <= vt_in;
      sx_ff <= sx_in;
      sd_ff <= sd_in;
      gp_ff <= gp_in;
      word0_ff <= word0_in;
      raw_ff <= raw_in;
      res_status_ff <= res_status_in;
      res_data_ff <= res_data_in;
      rsp_data_ff <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_size_ff <= rsp_size_in;
   end

endmodule

// ----- src/lmau_checker.sv -----
`include "linear_memory_access_unit_defines.svh"

module lmau_checker
   import lmau_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [63:0] rsp_load_data
);

   // A stalled response stays offered.
   `LMAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // One request at a time: no transfer right after an accepted one.
   `LMAU_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

   // Status codes stay within the defined set.
   `LMAU_ASSERT_NOW(a_status_range, rsp_valid, rsp_status <= STS_BADTYPE)

   // A failed request returns no data.
   `LMAU_ASSERT_NOW(a_err_no_data, rsp_valid && rsp_status != STS_OK, rsp_load_data == 64'd0)

endmodule

bind linear_memory_access_unit lmau_checker u_lmau_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_status   (rsp_ch.status),
   .rsp_load_data(rsp_ch.load_data)
);
